/* rtl/c2d_pkg.sv */
`default_nettype none
// c2d_pkg: shared widths, register codes and reset values for the 2-D convolution block
package c2d_pkg;

  localparam int PIX_W     = 16;  // pixel and weight width
  localparam int PROD_W    = 32;  // exact product width
  localparam int ACC_W     = 40;  // exact window sum width
  localparam int CFG_W     = 64;  // config data width
  localparam int CFG_IDX_W = 3;
  localparam int DIM_W     = 9;   // image width / height fields
  localparam int STRIDE_W  = 4;
  localparam int EXT_W     = 10;  // room for position + stride compares

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KROW0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd6;

  // register reset values
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 9'd226;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 9'd226;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 4'd1;

endpackage
`default_nettype wire

/* rtl/conv2d_valid_strided.sv */
`default_nettype none
// conv2d_valid_strided: streaming strided 2-D convolution over valid window positions (top level)
//
// Takes a padded image one pixel word per clock in raster order and returns one exact signed
// 40-bit weighted sum for every KSIZE x KSIZE window whose top-left corner sits on the
// stride grid; frame_last marks the final sum of a frame. Rate: one pixel per clock while
// pixel_stall is low, set by the single line-store RAM, which is read once at the accept edge
// and written back from stage 1 when that pixel advances. A result reaches the output register
// through these steps in order: line-store read at the accept edge, window shift, multiply,
// column sum, and final add into the output register. The previous KSIZE-1 rows live in
// one RAM holding one column of pixels per entry; the window itself is a row of KSIZE
// cells, each holding one window column and its multipliers, fed from the right and shifted
// left per pixel. A skid register behind the output lets one more result enter while the
// output word is stalled; pixel_stall rises only when that skid register is occupied. Writing
// image_width, image_height or stride restarts the frame; kernel writes feed the multipliers
// directly. Configure only while idle. There is no clearing pass after reset: every window
// pixel is written in its frame before it is read.
module conv2d_valid_strided
  import c2d_pkg::*;
#(
  parameter int KSIZE     = 3,
  parameter int MAX_WIDTH = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  // pixel input
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  logic signed [PIX_W-1:0] pixel,
  // result output
  output logic                    conv_valid,
  input  logic                    conv_stall,
  output logic signed [ACC_W-1:0] conv_value,
  output logic                    frame_last,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  // widest row the counters can see: the 9-bit width field caps it at 511
  localparam int WCAP  = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam int COLW  = $clog2(WCAP);
  localparam int COL_BITS = KSIZE * PIX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]    krow [KSIZE];
  logic [DIM_W-1:0]    img_width;
  logic [DIM_W-1:0]    img_height;
  logic [STRIDE_W-1:0] stride_cfg;
  logic                geo_write;

  assign geo_write = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                                cfg_index == CFG_STRIDE);

  // kernel rows beyond KSIZE have no storage; writes to them drop
  for (genvar g = 0; g < KSIZE; g++) begin : g_krow
    always_ff @(posedge clk) begin
      if (rst) begin
        krow[g] <= '0;
      end else if (cfg_we && cfg_index == CFG_KROW0 + CFG_IDX_W'(g)) begin
        krow[g] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= WIDTH_RST;
      img_height <= HEIGHT_RST;
      stride_cfg <= STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  img_width  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: img_height <= cfg_data[DIM_W-1:0];
        CFG_STRIDE: stride_cfg <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero means one, width clamped to the line store
  logic [DIM_W-1:0]    w_eff;
  logic [DIM_W-1:0]    h_eff;
  logic [STRIDE_W-1:0] s_eff;

  assign w_eff = (img_width == '0) ? DIM_W'(1) :
                 (img_width > DIM_W'(WCAP)) ? DIM_W'(WCAP) : img_width;
  assign h_eff = (img_height == '0) ? DIM_W'(1) : img_height;
  assign s_eff = (stride_cfg == '0) ? STRIDE_W'(1) : stride_cfg;

  // ---------------------------------------------------------------------------
  // Handshake: everything upstream of the output moves while the skid is empty
  // ---------------------------------------------------------------------------
  logic skid_valid;
  logic adv;
  logic accept;

  assign adv         = !skid_valid;
  assign pixel_stall = skid_valid;
  assign accept      = pixel_valid && adv;

  // ---------------------------------------------------------------------------
  // Stage 0: raster position, stride phases, window decision
  // ---------------------------------------------------------------------------
  logic [COLW-1:0]     col;
  logic [DIM_W-1:0]    row;
  logic [STRIDE_W-1:0] col_phase;
  logic [STRIDE_W-1:0] row_phase;
  logic [EXT_W-1:0]    col_inc;
  logic [EXT_W-1:0]    row_inc;
  logic                col_wrap;
  logic                row_wrap;
  logic [STRIDE_W-1:0] col_phase_step;
  logic [STRIDE_W-1:0] row_phase_step;
  logic                emit0;
  logic                last0;

  assign col_inc  = EXT_W'(col) + EXT_W'(1);
  assign row_inc  = EXT_W'(row) + EXT_W'(1);
  assign col_wrap = col_inc >= EXT_W'(w_eff);
  assign row_wrap = row_inc >= EXT_W'(h_eff);

  assign col_phase_step = (col_phase == s_eff - STRIDE_W'(1)) ? '0 : col_phase + STRIDE_W'(1);
  assign row_phase_step = (row_phase == s_eff - STRIDE_W'(1)) ? '0 : row_phase + STRIDE_W'(1);

  // A window ends here when both indexes are past the kernel edge and on the stride grid.
  // An aligned position below the size always fits, so no upper bound is needed; it is the
  // last one of its axis when one more stride would run off the edge.
  assign emit0 = (EXT_W'(col) >= EXT_W'(KSIZE - 1)) &&
                 (EXT_W'(row) >= EXT_W'(KSIZE - 1)) &&
                 (col_phase == '0) && (row_phase == '0);
  assign last0 = emit0 &&
                 (EXT_W'(col) + EXT_W'(s_eff) >= EXT_W'(w_eff)) &&
                 (EXT_W'(row) + EXT_W'(s_eff) >= EXT_W'(h_eff));

  always_ff @(posedge clk) begin
    if (rst || geo_write) begin
      col       <= '0;
      row       <= '0;
      col_phase <= '0;
      row_phase <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col       <= '0;
        col_phase <= '0;
        if (row_wrap) begin
          row       <= '0;
          row_phase <= '0;
        end else begin
          row       <= row_inc[DIM_W-1:0];
          row_phase <= (row_inc <= EXT_W'(KSIZE - 1)) ? '0 : row_phase_step;
        end
      end else begin
        col       <= col_inc[COLW-1:0];
        col_phase <= (col_inc <= EXT_W'(KSIZE - 1)) ? '0 : col_phase_step;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line-store read data arrives, new column formed and written back
  // ---------------------------------------------------------------------------
  logic                    v1;
  logic                    emit1;
  logic                    last1;
  logic signed [PIX_W-1:0] pix1;
  logic [COLW-1:0]         col1;
  logic [COL_BITS-1:0]     new_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix1  <= pixel;
      col1  <= col;
      emit1 <= emit0;
      last1 <= last0;
    end
  end

  // column slot i holds row (current - KSIZE + 1 + i); the newest pixel is on top
  if (KSIZE > 1) begin : g_lines
    logic [(KSIZE-1)*PIX_W-1:0] line_rd;

    c2d_ram #(
      .WIDTH ((KSIZE - 1) * PIX_W),
      .DEPTH (WCAP)
    ) u_line_store (
      .clk   (clk),
      .we    (adv && v1),
      .waddr (col1),
      .wdata (new_col[COL_BITS-1:PIX_W]),
      .re    (accept),
      .raddr (col),
      .rdata (line_rd)
    );

    assign new_col = {pix1, line_rd};
  end else begin : g_no_lines
    assign new_col = pix1;
  end

  // ---------------------------------------------------------------------------
  // Window cells: cell KSIZE-1 takes the new column, each cell feeds its left neighbor
  // ---------------------------------------------------------------------------
  logic [COL_BITS-1:0]     win_col [KSIZE];
  logic [COL_BITS-1:0]     w_col   [KSIZE];
  logic signed [ACC_W-1:0] psum    [KSIZE];

  for (genvar j = 0; j < KSIZE; j++) begin : g_cell
    logic [COL_BITS-1:0] feed;

    for (genvar i = 0; i < KSIZE; i++) begin : g_wt
      assign w_col[j][i*PIX_W +: PIX_W] = krow[i][j*PIX_W +: PIX_W];
    end

    if (j == KSIZE - 1) begin : g_head
      assign feed = new_col;
    end else begin : g_link
      assign feed = win_col[j+1];
    end

    c2d_cell #(
      .KSIZE (KSIZE)
    ) u_cell (
      .clk      (clk),
      .shift_en (adv && v1),
      .calc_en  (adv),
      .col_in   (feed),
      .weights  (w_col[j]),
      .col_out  (win_col[j]),
      .psum     (psum[j])
    );
  end

  // result tags follow the window through multiply (3) and column sum (4)
  logic e2, e3, e4;
  logic l2, l3, l4;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2 <= 1'b0;
      e3 <= 1'b0;
      e4 <= 1'b0;
    end else if (adv) begin
      e2 <= v1 && emit1;
      e3 <= e2;
      e4 <= e3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l2 <= last1;
      l3 <= l2;
      l4 <= l3;
    end
  end

  logic signed [ACC_W-1:0] total;

  always_comb begin
    total = '0;
    for (int j = 0; j < KSIZE; j++) begin
      total = total + psum[j];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid
  // ---------------------------------------------------------------------------
  logic                    new_res;
  logic                    out_take;
  logic signed [ACC_W-1:0] skid_value;
  logic                    skid_last;

  assign new_res  = adv && e4;
  assign out_take = conv_valid && !conv_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (new_res) begin
      if (!conv_valid || out_take) begin
        conv_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      conv_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        conv_value <= skid_value;
        frame_last <= skid_last;
      end
    end else if (new_res) begin
      if (!conv_valid || out_take) begin
        conv_value <= total;
        frame_last <= l4;
      end else begin
        skid_value <= total;
        skid_last  <= l4;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/c2d_ram.sv */
`default_nettype none
// c2d_ram: generic simple dual-port RAM, one write port, one registered read port
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/c2d_cell.sv */
`default_nettype none
// c2d_cell: one window column: shift register slot, per-row multipliers and column sum
module c2d_cell
  import c2d_pkg::*;
#(
  parameter int KSIZE = 3
) (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic                      calc_en,
  input  logic [KSIZE*PIX_W-1:0]    col_in,
  input  logic [KSIZE*PIX_W-1:0]    weights,
  output logic [KSIZE*PIX_W-1:0]    col_out,
  output logic signed [ACC_W-1:0]   psum
);

  logic signed [PROD_W-1:0] prod [KSIZE];
  logic signed [ACC_W-1:0]  col_sum;

  // window column, taken from the right-hand neighbor
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_out <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_en) begin
      for (int i = 0; i < KSIZE; i++) begin
        prod[i] <= $signed(col_out[i*PIX_W +: PIX_W]) * $signed(weights[i*PIX_W +: PIX_W]);
      end
    end
  end

  always_comb begin
    col_sum = '0;
    for (int i = 0; i < KSIZE; i++) begin
      col_sum = col_sum + ACC_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (calc_en) begin
      psum <= col_sum;
    end
  end

endmodule
`default_nettype wire

/* rtl/c2d_checker.sv */
`default_nettype none
// c2d_checker: port-level checks on the convolution block, bound to the top level
module c2d_checker
  import c2d_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    pixel_stall,
  input logic                    conv_valid,
  input logic                    conv_stall,
  input logic signed [ACC_W-1:0] conv_value,
  input logic                    frame_last
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    conv_valid && conv_stall |=> conv_valid)
    else $error("result word dropped while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    conv_valid && conv_stall |=> $stable(conv_value) && $stable(frame_last))
    else $error("result word changed while stalled");

  // the input only backs up behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> $past(conv_valid && conv_stall))
    else $error("pixel stall without a stalled result");

  // once a result word leaves, the input is open again
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    conv_valid && !conv_stall |=> !pixel_stall)
    else $error("pixel stall held after output drained");

endmodule

bind conv2d_valid_strided c2d_checker u_c2d_checker (.*);
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// testbench: strided 2-D convolution block on random frames, checked by a window-sum predictor
module testbench;
  import c2d_pkg::*;

  localparam int K             = 3;    // kernel size the block is built with
  localparam int MAXW          = 256;  // line store depth
  localparam int SETTLE        = 12;   // pipeline depth plus skid, with margin
  localparam int HOLD_CYCLES   = 80;   // long receiver hold-off, well past pipeline + skid depth
  localparam int PIXEL_BUDGET  = 1500;

  // index 7 is not a register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  // directed pixels: both rails, zero, -1, +1 and a few mid values
  localparam logic signed [PIX_W-1:0] RAIL_PIX [9] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh0100, 16'shFF00, 16'sh7FFF, 16'sh8000
  };

  typedef struct {
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } conv_word_t;

  typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  // Tracks registers, line stores and raster position; queues the window sums due.
  class window_sums;
    logic [CFG_W-1:0]        krow [4];
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic [STRIDE_W-1:0]     stride_reg;
    logic signed [PIX_W-1:0] lines [K][MAXW];
    int                      col;
    int                      row;
    conv_word_t              sums_due [$];
    int                      mismatches;

    function new();
      foreach (krow[i]) krow[i] = '0;
      foreach (lines[i, j]) lines[i][j] = '0;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      stride_reg = STRIDE_RST;
      col        = 0;
      row        = 0;
      mismatches = 0;
    endfunction

    function int eff_width();
      int w;
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > MAXW) w = MAXW;
      return w;
    endfunction

    function int eff_height();
      return (height_reg == '0) ? 1 : int'(height_reg);
    endfunction

    function int eff_stride();
      return (stride_reg == '0) ? 1 : int'(stride_reg);
    endfunction

    // last pixel index of the last window on an axis (size >= K only)
    function int last_pos(int size, int s);
      return ((size - K) / s) * s + (K - 1);
    endfunction

    function int frame_left();
      return eff_width() * eff_height() - (row * eff_width() + col);
    endfunction

    function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_WIDTH: begin
          width_reg = d[DIM_W-1:0];
          col = 0;
          row = 0;
        end
        CFG_HEIGHT: begin
          height_reg = d[DIM_W-1:0];
          col = 0;
          row = 0;
        end
        CFG_STRIDE: begin
          stride_reg = d[STRIDE_W-1:0];
          col = 0;
          row = 0;
        end
        CFG_SPARE: ;
        default: krow[idx - CFG_KROW0] = d;
      endcase
    endfunction

    function void take_pixel(logic signed [PIX_W-1:0] p);
      int         w, h, s, top, left, i, j;
      longint     acc;
      logic signed [PIX_W-1:0] wt;
      conv_word_t r;
      w = eff_width();
      h = eff_height();
      s = eff_stride();
      lines[row % K][col] = p;
      if (w >= K && h >= K && col >= K - 1 && row >= K - 1) begin
        if ((col - (K - 1)) % s == 0 && (row - (K - 1)) % s == 0 &&
            col <= last_pos(w, s) && row <= last_pos(h, s)) begin
          top  = row - (K - 1);
          left = col - (K - 1);
          acc  = 0;
          for (i = 0; i < K; i++) begin
            for (j = 0; j < K; j++) begin
              wt  = krow[i][PIX_W*j +: PIX_W];
              acc += longint'(lines[(top + i) % K][left + j]) * longint'(wt);
            end
          end
          r.value = acc[ACC_W-1:0];
          r.last  = (col == last_pos(w, s) && row == last_pos(h, s));
          sums_due.push_back(r);
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void match_result(logic signed [ACC_W-1:0] value, logic last);
      conv_word_t e;
      if (sums_due.size() == 0) begin
        $error("conv word with no sum due: conv_value %0d frame_last %0b", value, last);
        mismatches++;
        return;
      end
      e = sums_due.pop_front();
      if (value !== e.value) begin
        $error("conv_value: expected %0d, got %0d", e.value, value);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("frame_last: expected %0b, got %0b", e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  // DUT ports; the driven inputs are known from time zero
  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    pixel_valid = 1'b0;
  logic                    pixel_stall;
  logic signed [PIX_W-1:0] pixel       = '0;
  logic                    conv_valid;
  logic                    conv_stall  = 1'b0;
  logic signed [ACC_W-1:0] conv_value;
  logic                    frame_last;
  logic                    cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_W-1:0]        cfg_data    = '0;

  window_sums pred = new();

  // sender burst state; quiet turns sender gaps off
  int burst_left = 0;
  bit quiet      = 1'b0;

  // long hold-off request: the receiver counts its own cycles once it sees a change
  logic [7:0] hold_req  = '0;
  logic [7:0] hold_seen = '0;
  int         hold_left = 0;
  rx_mode_t   rx_mode   = RX_FLOW;
  int         mode_left = 0;

  conv2d_valid_strided #(
    .KSIZE      (K),
    .MAX_WIDTH  (MAXW)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .conv_valid (conv_valid),
    .conv_stall (conv_stall),
    .conv_value (conv_value),
    .frame_last (frame_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: checks each accepted conv word, then picks next cycle's stall.
  // Stall modes change in random stretches: free flow, light, heavy and toggling;
  // a hold request forces a long run of stall cycles so the pipeline backs up.
  always @(posedge clk) begin
    if (rst) begin
      conv_stall <= 1'b0;
    end else begin
      if (conv_valid && !conv_stall) pred.match_result(conv_value, frame_last);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        conv_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_FLOW:  conv_stall <= 1'b0;
          RX_LIGHT: conv_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: conv_stall <= ($urandom_range(0, 3) != 0);
          default:  conv_stall <= ~conv_stall;
        endcase
      end
    end
  end

  // Register write; the caller drops cfg_we once after its last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    pred.take_config(idx, d);
  endtask

  // any geometry write restarts the frame
  task automatic set_geometry(input int w, input int h, input int s);
    cfg_write(CFG_WIDTH, CFG_W'(w));
    cfg_write(CFG_HEIGHT, CFG_W'(h));
    cfg_write(CFG_STRIDE, CFG_W'(s));
  endtask

  // Sender stops and waits for every due sum, then idles with pixel_valid low so
  // the pipeline can clear.
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (pred.sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One pixel word. Bursts of random length, random gaps in between, and now
  // and then a full pause until the output side has drained.
  task automatic send_pixel(input logic signed [PIX_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 40) == 0) begin
        wait_idle();
      end
    end
    burst_left--;
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    pred.take_pixel(p);
  endtask

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_krow();
    case ($urandom_range(0, 7))
      0:       return {4{16'h8000}};
      1:       return {4{16'h7FFF}};
      2:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int phase, sent, n, w, h, s, left, frame, i;
    bit big;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // All weights and pixels at the negative rail: largest positive sum.
    for (i = 0; i < 4; i++) cfg_write(CFG_IDX_W'(CFG_KROW0 + i), {4{16'h8000}});
    cfg_write(CFG_SPARE, {$urandom, $urandom});
    set_geometry(3, 3, 1);
    cfg_we <= 1'b0;
    repeat (9) send_pixel(16'sh8000);
    wait_idle();

    // Mixed rail weights, zero stride (acts as one), rail and near-zero pixels.
    cfg_write(CFG_IDX_W'(CFG_KROW0 + 0), {16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF});
    cfg_write(CFG_IDX_W'(CFG_KROW0 + 1), {16'h0000, 16'hFFFF, 16'h0001, 16'h1000});
    cfg_write(CFG_IDX_W'(CFG_KROW0 + 2), {16'h0000, 16'h8000, 16'h7FFF, 16'h8000});
    set_geometry(3, 3, 0);
    cfg_we <= 1'b0;
    for (i = 0; i < 9; i++) send_pixel(RAIL_PIX[i]);
    wait_idle();

    // Zero width (acts as one) and a height below the kernel: nothing comes out.
    set_geometry(0, 2, 1);
    cfg_we <= 1'b0;
    repeat (3) send_pixel(rand_pixel());

    // --- random phases ---
    // Mostly small frames sent whole; some partial frames, some phases that
    // keep the geometry and run on mid-frame. A few fixed phases early on cover
    // the pressure case and the size extremes.
    sent  = 0;
    phase = 0;
    while (sent < PIXEL_BUDGET) begin
      wait_idle();
      quiet = 1'b0;
      big   = 1'b0;
      for (i = 0; i < 4; i++) begin
        if ($urandom_range(0, 2) == 0) cfg_write(CFG_IDX_W'(CFG_KROW0 + i), rand_krow());
      end
      if ($urandom_range(0, 9) == 0) cfg_write(CFG_SPARE, {$urandom, $urandom});
      case (phase)
        1: begin
          // receiver holds off while the sender streams a whole frame without gaps
          set_geometry(8, 8, 1);
          quiet = 1'b1;
          big   = 1'b1;
          hold_req <= hold_req + 8'd1;
        end
        2: begin
          // width beyond the line store clamps to MAXW; full-width rows
          set_geometry(400, 3, 1);
          big = 1'b1;
        end
        3: begin
          // tall frame at the largest stride
          set_geometry(3, 64, 15);
          big = 1'b1;
        end
        default: begin
          if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
              0: begin
                w = $urandom_range(0, 2);
                h = $urandom_range(1, 8);
                s = $urandom_range(0, 3);
              end
              1: begin
                w = $urandom_range(3, 10);
                h = $urandom_range(0, 2);
                s = $urandom_range(0, 3);
              end
              2: begin
                w = $urandom_range(10, 40);
                h = $urandom_range(9, 20);
                s = $urandom_range(4, 15);
              end
              3: begin
                w = $urandom_range(3, 10);
                h = $urandom_range(3, 10);
                s = 0;
              end
              default: begin
                w = $urandom_range(3, 12);
                h = $urandom_range(3, 10);
                s = $urandom_range(1, 3);
              end
            endcase
            set_geometry(w, h, s);
          end
        end
      endcase
      cfg_we <= 1'b0;

      left  = pred.frame_left();
      frame = pred.eff_width() * pred.eff_height();
      if (big) begin
        n = left;
      end else begin
        case ($urandom_range(0, 3))
          0:       n = left;
          1:       n = left + frame;
          2:       n = $urandom_range(1, left);
          default: n = left + $urandom_range(1, frame);
        endcase
      end
      repeat (n) send_pixel(rand_pixel());
      sent += n;
      phase++;
    end

    wait_idle();
    if (pred.mismatches == 0 && pred.sums_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
